// ----- hw/rtl/pcfl_pkg.sv -----
// Shared types and constants for the page cache FIFO/LRU replacement list.
package pcfl_pkg;

  localparam int CAPACITY       = 128;
  localparam int IDX_W          = $clog2(CAPACITY);
  localparam int CNT_W          = $clog2(CAPACITY + 1);
  localparam int PAGE_W         = 16;
  localparam int KIND_W         = 2;
  localparam int LIMIT_W        = 7;
  localparam int EVCNT_W        = 6;
  localparam int EVICT_PER_ITEM = 63;

  localparam logic [KIND_W-1:0] KIND_HIT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVICT  = 2'd2;

  localparam logic REG_LRU_MODE    = 1'b0;
  localparam logic REG_ENTRY_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    OP_HOLD      = 2'd0,
    OP_SHIFT_ALL = 2'd1,
    OP_REFRESH   = 2'd2,
    OP_APPEND    = 2'd3
  } chain_op_t;

  typedef struct packed {
    chain_op_t        op;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] pos;
  } chain_cmd_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/pcfl_cell.sv -----
// One list cell: holds a page, compares it with the key and shifts toward the head.
module pcfl_cell (
  input  logic                        clk,
  input  pcfl_pkg::cell_ctrl_t        ctrl,
  input  logic                        occupied,
  input  logic [pcfl_pkg::PAGE_W-1:0] key_page,
  input  logic [pcfl_pkg::PAGE_W-1:0] right_page,
  output logic [pcfl_pkg::PAGE_W-1:0] page,
  output logic                        match
);
  import pcfl_pkg::*;

  logic [PAGE_W-1:0] page_r;
  logic [PAGE_W-1:0] page_nxt;

  always_comb begin
    page_nxt = page_r;
    if (ctrl.load) begin
      page_nxt = key_page;
    end else if (ctrl.shift) begin
      page_nxt = right_page;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

  assign page  = page_r;
  assign match = occupied && (page_r == key_page);
endmodule

// ----- hw/rtl/pcfl_chain.sv -----
// Row of list cells with per-cell control decode and match position encode.
module pcfl_chain (
  input  logic                        clk,
  input  pcfl_pkg::chain_cmd_t        cmd,
  input  logic [pcfl_pkg::PAGE_W-1:0] key_page,
  output logic                        hit,
  output logic [pcfl_pkg::IDX_W-1:0]  hit_pos,
  output logic [pcfl_pkg::PAGE_W-1:0] head_page
);
  import pcfl_pkg::*;

  logic [PAGE_W-1:0]   pages [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic [CNT_W-1:0]    count_m1;

  assign count_m1 = cmd.count - CNT_W'(1);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctrl_t        ctrl;
    logic [PAGE_W-1:0] right;

    always_comb begin
      ctrl = '0;
      case (cmd.op)
        OP_SHIFT_ALL: ctrl.shift = 1'b1;
        // Close the gap at the hit and put the hit page at the newest end.
        OP_REFRESH: begin
          ctrl.shift = (IDX_W'(i) >= cmd.pos) && (CNT_W'(i) < count_m1);
          ctrl.load  = (CNT_W'(i) == count_m1);
        end
        OP_APPEND: ctrl.load = (CNT_W'(i) == cmd.count);
        default: ctrl = '0;
      endcase
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = pages[i+1];
    end

    pcfl_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (CNT_W'(i) < cmd.count),
      .key_page   (key_page),
      .right_page (right),
      .page       (pages[i]),
      .match      (match[i])
    );
  end

  // Resident pages are distinct, so at most one cell matches.
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        hit_pos = hit_pos | IDX_W'(i);
      end
    end
  end

  assign hit       = |match;
  assign head_page = pages[0];
endmodule

// ----- hw/rtl/page_cache_fifo_lru_replacement_core.sv -----
// Top level: command interface, configuration registers and sequencing of the list.
// A page is taken when start is high and busy is low. All 128 list cells compare
// the page at once in the search state; a hit gives a single result word. A miss
// gives the insert word and then one eviction word per cycle, since the list
// evicts through its single head cell; a miss on a full list first gives one
// eviction, made in the resolve state ahead of the insert. An item gives at most
// 63 evictions. Each result word is shown for exactly one cycle with out_valid and
// the receiver cannot stall; out_last marks the final word of the item.
// Configuration writes are always ready; the user must keep them to idle
// periods, as the block itself does not enforce it.
module page_cache_fifo_lru_replacement_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [pcfl_pkg::PAGE_W-1:0]  in_page,
  output logic                         out_valid,
  output logic [pcfl_pkg::KIND_W-1:0]  out_kind,
  output logic [pcfl_pkg::PAGE_W-1:0]  out_result_page,
  output logic [pcfl_pkg::CNT_W-1:0]   out_occupancy,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [pcfl_pkg::LIMIT_W-1:0] cfg_data
);
  import pcfl_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SEARCH  = 5'b00010,
    ST_RESOLVE = 5'b00100,
    ST_INSERT  = 5'b01000,
    ST_EVICT   = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [PAGE_W-1:0]  page_r, page_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [EVCNT_W-1:0] evcnt_r, evcnt_nxt;
  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic               lru_r, lru_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;

  logic               ov_r, ov_nxt;
  logic [KIND_W-1:0]  okind_r, okind_nxt;
  logic [PAGE_W-1:0]  opage_r, opage_nxt;
  logic [CNT_W-1:0]   oocc_r, oocc_nxt;
  logic               olast_r, olast_nxt;

  chain_cmd_t         cmd;
  logic               chain_hit;
  logic [IDX_W-1:0]   chain_pos;
  logic [PAGE_W-1:0]  head_page;

  logic [CNT_W-1:0]   count_p1, count_m1;
  logic [EVCNT_W-1:0] evcnt_p1;
  logic               more_after_insert, more_after_evict;

  pcfl_chain u_chain (
    .clk       (clk),
    .cmd       (cmd),
    .key_page  (page_r),
    .hit       (chain_hit),
    .hit_pos   (chain_pos),
    .head_page (head_page)
  );

  assign count_p1 = count_r + CNT_W'(1);
  assign count_m1 = count_r - CNT_W'(1);
  assign evcnt_p1 = evcnt_r + EVCNT_W'(1);

  assign more_after_insert = (count_p1 > CNT_W'(limit_r)) &&
                             (evcnt_r < EVCNT_W'(EVICT_PER_ITEM));
  assign more_after_evict  = (count_m1 > CNT_W'(limit_r)) && (count_m1 != '0) &&
                             (evcnt_p1 < EVCNT_W'(EVICT_PER_ITEM));

  always_comb begin
    lru_nxt   = lru_r;
    limit_nxt = limit_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_LRU_MODE:    lru_nxt   = cfg_data[0];
        REG_ENTRY_LIMIT: limit_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    page_nxt  = page_r;
    count_nxt = count_r;
    evcnt_nxt = evcnt_r;
    hit_nxt   = hit_r;
    pos_nxt   = pos_r;
    ov_nxt    = 1'b0;
    okind_nxt = okind_r;
    opage_nxt = opage_r;
    oocc_nxt  = oocc_r;
    olast_nxt = olast_r;
    cmd.op    = OP_HOLD;
    cmd.count = count_r;
    cmd.pos   = pos_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          page_nxt  = in_page;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        hit_nxt   = chain_hit;
        pos_nxt   = chain_pos;
        evcnt_nxt = '0;
        state_nxt = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (hit_r) begin
          if (lru_r) begin
            cmd.op = OP_REFRESH;
          end
          ov_nxt    = 1'b1;
          okind_nxt = KIND_HIT;
          opage_nxt = page_r;
          oocc_nxt  = count_r;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          // A full list gives up its oldest page before the insert.
          if (count_r >= CNT_W'(CAPACITY)) begin
            cmd.op    = OP_SHIFT_ALL;
            count_nxt = count_m1;
            evcnt_nxt = EVCNT_W'(1);
            ov_nxt    = 1'b1;
            okind_nxt = KIND_EVICT;
            opage_nxt = head_page;
            oocc_nxt  = count_m1;
            olast_nxt = 1'b0;
          end
          state_nxt = ST_INSERT;
        end
      end
      ST_INSERT: begin
        cmd.op    = OP_APPEND;
        count_nxt = count_p1;
        ov_nxt    = 1'b1;
        okind_nxt = KIND_INSERT;
        opage_nxt = page_r;
        oocc_nxt  = count_p1;
        olast_nxt = !more_after_insert;
        state_nxt = more_after_insert ? ST_EVICT : ST_IDLE;
      end
      ST_EVICT: begin
        cmd.op    = OP_SHIFT_ALL;
        count_nxt = count_m1;
        evcnt_nxt = evcnt_p1;
        ov_nxt    = 1'b1;
        okind_nxt = KIND_EVICT;
        opage_nxt = head_page;
        oocc_nxt  = count_m1;
        olast_nxt = !more_after_evict;
        state_nxt = more_after_evict ? ST_EVICT : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      evcnt_r <= '0;
      hit_r   <= 1'b0;
      lru_r   <= 1'b0;
      limit_r <= LIMIT_W'(30);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      evcnt_r <= evcnt_nxt;
      hit_r   <= hit_nxt;
      lru_r   <= lru_nxt;
      limit_r <= limit_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r  <= page_nxt;
    pos_r   <= pos_nxt;
    okind_r <= okind_nxt;
    opage_r <= opage_nxt;
    oocc_r  <= oocc_nxt;
    olast_r <= olast_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = ov_r;
  assign out_kind        = okind_r;
  assign out_result_page = opage_r;
  assign out_occupancy   = oocc_r;
  assign out_last        = olast_r;
endmodule

// ----- test/page_cache_fifo_lru_replacement_checker.sv -----
// Checker that predicts the replacement list's result words and compares them on the fly.
module page_cache_fifo_lru_replacement_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [pcfl_pkg::PAGE_W-1:0]  in_page,
  input  logic                         out_valid,
  input  logic [pcfl_pkg::KIND_W-1:0]  out_kind,
  input  logic [pcfl_pkg::PAGE_W-1:0]  out_result_page,
  input  logic [pcfl_pkg::CNT_W-1:0]   out_occupancy,
  input  logic                         out_last,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [pcfl_pkg::LIMIT_W-1:0] cfg_data,
  output int                           fail_count,
  output int                           pending
);
  import pcfl_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PAGE_W-1:0] page;
    logic [CNT_W-1:0]  occupancy;
    logic              last;
  } result_word_t;

  logic [PAGE_W-1:0]  resident_pages [CAPACITY];
  int                 resident_count = 0;
  logic               lru_on = 1'b0;
  logic [LIMIT_W-1:0] page_limit = 7'd30;
  result_word_t       expected_words [$];
  int                 mismatch_total = 0;
  int                 words_waiting = 0;

  assign fail_count = mismatch_total;
  assign pending    = words_waiting;

  task automatic push_word(input logic [KIND_W-1:0] kind, input logic [PAGE_W-1:0] pg,
                           input int occ);
    expected_words.push_back('{kind, pg, occ[CNT_W-1:0], 1'b0});
  endtask

  task automatic evict_oldest(output logic [PAGE_W-1:0] victim);
    victim = resident_pages[0];
    for (int i = 1; i < resident_count; i++)
      resident_pages[i-1] = resident_pages[i];
    resident_count--;
  endtask

  task automatic predict_page(input logic [PAGE_W-1:0] pg);
    int                pos;
    int                evicted;
    logic [PAGE_W-1:0] victim;
    result_word_t      tail;
    pos     = -1;
    evicted = 0;
    for (int i = 0; i < resident_count; i++)
      if (pos < 0 && resident_pages[i] == pg) pos = i;
    if (pos >= 0) begin
      // A hit never evicts, even with a surplus over the limit.
      if (lru_on) begin
        for (int i = pos + 1; i < resident_count; i++)
          resident_pages[i-1] = resident_pages[i];
        resident_pages[resident_count-1] = pg;
      end
      push_word(KIND_HIT, pg, resident_count);
    end else begin
      if (resident_count >= CAPACITY) begin
        evict_oldest(victim);
        evicted++;
        push_word(KIND_EVICT, victim, resident_count);
      end
      resident_pages[resident_count] = pg;
      resident_count++;
      push_word(KIND_INSERT, pg, resident_count);
      while (resident_count > int'(page_limit) && resident_count > 0 &&
             evicted < EVICT_PER_ITEM) begin
        evict_oldest(victim);
        evicted++;
        push_word(KIND_EVICT, victim, resident_count);
      end
    end
    tail      = expected_words.pop_back();
    tail.last = 1'b1;
    expected_words.push_back(tail);
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      mismatch_total++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_word_t w;
    if (!rst_n) begin
      resident_count = 0;
      lru_on         = 1'b0;
      page_limit     = 7'd30;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_LRU_MODE) lru_on = cfg_data[0];
        else page_limit = cfg_data;
      end
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: kind %0d page %0d",
                 out_kind, out_result_page);
          mismatch_total++;
        end else begin
          w = expected_words.pop_front();
          check_field("kind", w.kind, out_kind);
          check_field("result_page", w.page, out_result_page);
          check_field("occupancy", w.occupancy, out_occupancy);
          check_field("last", w.last, out_last);
        end
      end
      if (start && !busy) predict_page(in_page);
    end
    words_waiting = expected_words.size();
  end

endmodule

// ----- test/page_cache_fifo_lru_replacement_core_test.sv -----
// Testbench top: drives pages and register writes into the replacement list and gives the verdict.
module page_cache_fifo_lru_replacement_core_test;
  import pcfl_pkg::*;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               start     = 1'b0;
  logic               busy;
  logic [PAGE_W-1:0]  in_page   = '0;
  logic               out_valid;
  logic [KIND_W-1:0]  out_kind;
  logic [PAGE_W-1:0]  out_result_page;
  logic [CNT_W-1:0]   out_occupancy;
  logic               out_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = REG_LRU_MODE;
  logic [LIMIT_W-1:0] cfg_data  = '0;
  int                 fail_count;
  int                 pending;
  int                 idle_pct  = 0;

  page_cache_fifo_lru_replacement_core u_top (
    .clk, .rst_n, .start, .busy, .in_page,
    .out_valid, .out_kind, .out_result_page, .out_occupancy, .out_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  page_cache_fifo_lru_replacement_checker u_check (
    .clk, .rst_n, .start, .busy, .in_page,
    .out_valid, .out_kind, .out_result_page, .out_occupancy, .out_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the page is taken.
  task automatic send_page(input logic [PAGE_W-1:0] pg);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_page <= pg;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain_list();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Leaves cfg_valid high so that back-to-back writes need no extra assignment.
  task automatic write_reg(input logic idx, input logic [LIMIT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_config(input logic lru, input logic [LIMIT_W-1:0] limit);
    drain_list();
    write_reg(REG_LRU_MODE, {{(LIMIT_W-1){1'b0}}, lru});
    write_reg(REG_ENTRY_LIMIT, limit);
    cfg_valid <= 1'b0;
  endtask

  // Most pages come from a window of pool pages, so a small pool makes hits and refreshes common.
  task automatic run_phase(input logic lru, input logic [LIMIT_W-1:0] limit, input int count,
                           input int pool, input int idle);
    logic [PAGE_W-1:0] base;
    logic [PAGE_W-1:0] pg;
    set_config(lru, limit);
    idle_pct = idle;
    base     = PAGE_W'($urandom_range(0, 65535));
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) pg = PAGE_W'($urandom_range(0, 65535));
      else pg = base + PAGE_W'($urandom_range(0, pool - 1));
      send_page(pg);
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Register values straight out of reset.
    send_page(16'h0000);
    send_page(16'hFFFF);

    // FIFO: a hit keeps the order, so the oldest page still goes first.
    set_config(1'b0, 7'd5);
    send_page(16'hAAAA);
    send_page(16'h5555);
    send_page(16'h0001);
    send_page(16'h0000);
    send_page(16'h0002);
    send_page(16'hFFFF);

    // LRU: the refreshed page survives the next eviction.
    set_config(1'b1, 7'd5);
    send_page(16'hAAAA);
    send_page(16'h0003);
    send_page(16'h0001);

    // A zero limit evicts everything, the word just inserted too.
    set_config(1'b1, 7'd0);
    send_page(16'h8000);
    send_page(16'h7FFF);

    set_config(1'b0, 7'd3);
    send_page(16'h0010);
    send_page(16'h0020);
    send_page(16'h0030);
    send_page(16'h0040);
    send_page(16'h0020);

    run_phase(1'b0, 7'd5, 22, 12, 0);
    run_phase(1'b1, 7'd8, 22, 16, 71);
    run_phase(1'b1, 7'd100, 75, 65536, 0);
    // Dropping the limit far below the occupancy needs more than one item's evictions.
    run_phase(1'b0, 7'd0, 4, 4, 23);
    run_phase(1'b1, 7'd127, 20, 24, 23);

    drain_list();
    repeat (EVICT_PER_ITEM + 8) @(negedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
